/* rtl/x86_integer_alu_with_flags_defines.svh */
// Assertion macros for the x86 integer ALU checker.
`ifndef X86_INTEGER_ALU_WITH_FLAGS_DEFINES_SVH
`define X86_INTEGER_ALU_WITH_FLAGS_DEFINES_SVH

// Checked outside reset; expects clk and rst in scope.
`define X86ALU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define X86ALU_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/x86alu_pkg.sv */
// Shared types, codes and helper functions for the x86 integer ALU.
`timescale 1ns / 1ps

package x86alu_pkg;

  typedef enum logic [4:0] {
    CMD_MOV    = 5'd0,
    CMD_MOVZX  = 5'd1,
    CMD_MOVSXD = 5'd2,
    CMD_NOP    = 5'd3,
    CMD_ADD    = 5'd4,
    CMD_INC    = 5'd5,
    CMD_SUB    = 5'd6,
    CMD_CMP    = 5'd7,
    CMD_IMUL   = 5'd8,
    CMD_AND    = 5'd9,
    CMD_OR     = 5'd10,
    CMD_XOR    = 5'd11,
    CMD_TEST   = 5'd12,
    CMD_SHL    = 5'd13,
    CMD_SHR    = 5'd14,
    CMD_CDQE   = 5'd15,
    CMD_JMP    = 5'd16,
    CMD_JE     = 5'd17,
    CMD_JNE    = 5'd18,
    CMD_JBE    = 5'd19,
    CMD_JL     = 5'd20,
    CMD_JGE    = 5'd21,
    CMD_JLE    = 5'd22
  } cmd_t;

  typedef enum logic [2:0] {
    SZ_NONE  = 3'd0,
    SZ_BYTE  = 3'd1,
    SZ_WORD  = 3'd2,
    SZ_DWORD = 3'd3,
    SZ_QWORD = 3'd4
  } sz_t;

  localparam int FLAG_CF = 0;
  localparam int FLAG_PF = 1;
  localparam int FLAG_AF = 2;
  localparam int FLAG_ZF = 3;
  localparam int FLAG_SF = 4;
  localparam int FLAG_OF = 5;

  localparam logic [1:0] REG_CODE_B = 2'd0;
  localparam logic [1:0] REG_CODE_W = 2'd1;
  localparam logic [1:0] REG_CODE_D = 2'd2;
  localparam logic [1:0] REG_CODE_Q = 2'd3;

  localparam logic [7:0] RESET_CODE_B = 8'd98;
  localparam logic [7:0] RESET_CODE_W = 8'd119;
  localparam logic [7:0] RESET_CODE_D = 8'd100;
  localparam logic [7:0] RESET_CODE_Q = 8'd113;

  typedef struct packed {
    logic [7:0] code_b;
    logic [7:0] code_w;
    logic [7:0] code_d;
    logic [7:0] code_q;
  } cfg_t;

  // Execute stage result; for imul the product is summed in the next stage.
  typedef struct packed {
    logic [63:0] result;
    logic        wb;
    logic        taken;
    logic [5:0]  flags;
    logic        is_mul;
    logic [63:0] p_ll;
    logic [31:0] p_lh;
    logic [31:0] p_hl;
    logic [63:0] keep;
    logic [63:0] mask;
  } exec_t;

  function automatic sz_t decode_size(input logic [7:0] code, input cfg_t cfg);
    sz_t sz;
    if (code == cfg.code_q) sz = SZ_QWORD;
    else if (code == cfg.code_d) sz = SZ_DWORD;
    else if (code == cfg.code_w) sz = SZ_WORD;
    else if (code == cfg.code_b) sz = SZ_BYTE;
    else sz = SZ_NONE;
    return sz;
  endfunction

  function automatic logic [63:0] size_mask(input sz_t sz);
    logic [63:0] m;
    case (sz)
      SZ_QWORD: m = {64{1'b1}};
      SZ_DWORD: m = {32'd0, {32{1'b1}}};
      SZ_WORD:  m = {48'd0, {16{1'b1}}};
      default:  m = {56'd0, {8{1'b1}}};
    endcase
    return m;
  endfunction

  function automatic logic [63:0] size_sign(input sz_t sz);
    logic [63:0] s;
    case (sz)
      SZ_QWORD: s = 64'h8000_0000_0000_0000;
      SZ_DWORD: s = 64'h0000_0000_8000_0000;
      SZ_WORD:  s = 64'h0000_0000_0000_8000;
      default:  s = 64'h0000_0000_0000_0080;
    endcase
    return s;
  endfunction

  // Bits of the old destination that survive a sized write.
  function automatic logic [63:0] merge_keep(input sz_t sz, input logic is_reg);
    logic [63:0] k;
    if (sz == SZ_QWORD || (sz == SZ_DWORD && is_reg)) k = 64'd0;
    else k = ~size_mask(sz);
    return k;
  endfunction

  function automatic logic [63:0] merge(input logic [63:0] d, input logic [63:0] val,
                                        input sz_t sz, input logic is_reg);
    return (d & merge_keep(sz, is_reg)) | (val & size_mask(sz));
  endfunction

  function automatic logic [63:0] sext32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

endpackage

/* rtl/x86_integer_alu_with_flags.sv */
// A transfer passes the input register, the execute register and the output register in order.
// One item per cycle while out_stall is low; a stalled output holds back the stages behind it.
// The execute stage holds the 32x32 partial products; the next stage sums them for imul.
// Flags are updated in order as items leave the input register, so jumps see all older cmp/test.
// Synchronous reset clears the stage valids and flags and loads the default size codes.
`timescale 1ns / 1ps

module x86_integer_alu_with_flags (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  cmd,
  input  logic        dest_is_register,
  input  logic [7:0]  dest_size,
  input  logic [7:0]  src_size,
  input  logic [63:0] dest_value,
  input  logic [63:0] src_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_value,
  output logic        write_back,
  output logic        branch_taken,
  output logic [5:0]  flag_bits
);

  x86alu_pkg::cfg_t  cfg;
  x86alu_pkg::exec_t ex_next;
  x86alu_pkg::exec_t ex;
  logic [63:0]       final_value;

  logic        v1;
  logic        v2;
  logic        en1;
  logic        en2;
  logic        en3;
  logic [4:0]  cmd_r;
  logic        dest_is_register_r;
  logic [7:0]  dest_size_r;
  logic [7:0]  src_size_r;
  logic [63:0] dest_value_r;
  logic [63:0] src_value_r;
  logic [5:0]  status_flags;

  assign en3      = !out_valid || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  x86alu_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  x86alu_exec u_exec (
    .cfg              (cfg),
    .cmd              (cmd_r),
    .dest_is_register (dest_is_register_r),
    .dest_size        (dest_size_r),
    .src_size         (src_size_r),
    .dest_value       (dest_value_r),
    .src_value        (src_value_r),
    .status_flags     (status_flags),
    .ex               (ex_next)
  );

  x86alu_finish u_finish (
    .ex           (ex),
    .result_value (final_value)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      out_valid    <= 1'b0;
      status_flags <= 6'd0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) out_valid <= v2;
      if (en2 && v1) status_flags <= ex_next.flags;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en1) begin
      cmd_r              <= cmd;
      dest_is_register_r <= dest_is_register;
      dest_size_r        <= dest_size;
      src_size_r         <= src_size;
      dest_value_r       <= dest_value;
      src_value_r        <= src_value;
    end
    if (en2) ex <= ex_next;
    if (en3) begin
      result_value <= final_value;
      write_back   <= ex.wb;
      branch_taken <= ex.taken;
      flag_bits    <= ex.flags;
    end
  end

endmodule

/* rtl/x86alu_cfg_regs.sv */
// APB-style size code registers.
`timescale 1ns / 1ps

module x86alu_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output x86alu_pkg::cfg_t    cfg
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_b <= x86alu_pkg::RESET_CODE_B;
      cfg.code_w <= x86alu_pkg::RESET_CODE_W;
      cfg.code_d <= x86alu_pkg::RESET_CODE_D;
      cfg.code_q <= x86alu_pkg::RESET_CODE_Q;
    end else if (wr_en) begin
      case (idx)
        x86alu_pkg::REG_CODE_B: cfg.code_b <= pwdata[7:0];
        x86alu_pkg::REG_CODE_W: cfg.code_w <= pwdata[7:0];
        x86alu_pkg::REG_CODE_D: cfg.code_d <= pwdata[7:0];
        x86alu_pkg::REG_CODE_Q: cfg.code_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      x86alu_pkg::REG_CODE_B: prdata = {24'd0, cfg.code_b};
      x86alu_pkg::REG_CODE_W: prdata = {24'd0, cfg.code_w};
      x86alu_pkg::REG_CODE_D: prdata = {24'd0, cfg.code_d};
      x86alu_pkg::REG_CODE_Q: prdata = {24'd0, cfg.code_q};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/x86alu_exec.sv */
// Execute stage: size decode, ALU ops, flags, branch test and imul partial products.
`timescale 1ns / 1ps

module x86alu_exec (
  input  x86alu_pkg::cfg_t  cfg,
  input  logic [4:0]        cmd,
  input  logic              dest_is_register,
  input  logic [7:0]        dest_size,
  input  logic [7:0]        src_size,
  input  logic [63:0]       dest_value,
  input  logic [63:0]       src_value,
  input  logic [5:0]        status_flags,
  output x86alu_pkg::exec_t ex
);

  x86alu_pkg::sz_t dsz;
  x86alu_pkg::sz_t ssz;
  logic [63:0] m;
  logic [63:0] sg;
  logic [63:0] a;
  logic [63:0] b;
  logic        sized;
  logic [5:0]  cnt;
  logic [63:0] r_cmp;
  logic [63:0] r_test;
  logic [5:0]  cmp_flags;
  logic [5:0]  test_flags;
  logic        zf;
  logic        cf;
  logic        lt;

  always_comb begin
    dsz    = x86alu_pkg::decode_size(dest_size, cfg);
    ssz    = x86alu_pkg::decode_size(src_size, cfg);
    m      = x86alu_pkg::size_mask(dsz);
    sg     = x86alu_pkg::size_sign(dsz);
    a      = dest_value & m;
    b      = src_value & m;
    sized  = (dsz != x86alu_pkg::SZ_NONE);
    cnt    = (dsz == x86alu_pkg::SZ_QWORD) ? src_value[5:0] : {1'b0, src_value[4:0]};
    r_cmp  = (a - b) & m;
    r_test = a & b;

    cmp_flags                      = '0;
    cmp_flags[x86alu_pkg::FLAG_CF] = (a < b);
    cmp_flags[x86alu_pkg::FLAG_PF] = ~^r_cmp[7:0];
    cmp_flags[x86alu_pkg::FLAG_AF] = a[4] ^ b[4] ^ r_cmp[4];
    cmp_flags[x86alu_pkg::FLAG_ZF] = (r_cmp == 64'd0);
    cmp_flags[x86alu_pkg::FLAG_SF] = |(r_cmp & sg);
    cmp_flags[x86alu_pkg::FLAG_OF] = |((a ^ b) & (a ^ r_cmp) & sg);

    test_flags                      = '0;
    test_flags[x86alu_pkg::FLAG_PF] = ~^r_test[7:0];
    test_flags[x86alu_pkg::FLAG_ZF] = (r_test == 64'd0);
    test_flags[x86alu_pkg::FLAG_SF] = |(r_test & sg);

    zf = status_flags[x86alu_pkg::FLAG_ZF];
    cf = status_flags[x86alu_pkg::FLAG_CF];
    lt = status_flags[x86alu_pkg::FLAG_SF] ^ status_flags[x86alu_pkg::FLAG_OF];

    ex        = '0;
    ex.result = dest_value;
    ex.flags  = status_flags;
    ex.p_ll   = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    ex.p_lh   = a[31:0] * b[63:32];
    ex.p_hl   = a[63:32] * b[31:0];
    ex.keep   = x86alu_pkg::merge_keep(dsz, dest_is_register);
    ex.mask   = m;

    case (cmd)
      x86alu_pkg::CMD_MOV: begin
        if (sized) begin
          ex.result = x86alu_pkg::merge(dest_value, src_value, dsz, dest_is_register);
          ex.wb     = 1'b1;
        end
      end
      x86alu_pkg::CMD_MOVZX: begin
        if (dsz == x86alu_pkg::SZ_QWORD || dsz == x86alu_pkg::SZ_DWORD) begin
          if (ssz == x86alu_pkg::SZ_WORD || ssz == x86alu_pkg::SZ_BYTE) begin
            ex.result = x86alu_pkg::merge(dest_value, src_value & x86alu_pkg::size_mask(ssz),
                                          dsz, dest_is_register);
            ex.wb     = 1'b1;
          end
        end else if (dsz == x86alu_pkg::SZ_WORD) begin
          ex.result = x86alu_pkg::merge(dest_value, {56'd0, src_value[7:0]},
                                        x86alu_pkg::SZ_WORD, dest_is_register);
          ex.wb     = 1'b1;
        end
      end
      x86alu_pkg::CMD_MOVSXD: begin
        ex.result = x86alu_pkg::sext32(src_value);
        ex.wb     = 1'b1;
      end
      x86alu_pkg::CMD_ADD: begin
        if (sized) begin
          ex.result = x86alu_pkg::merge(dest_value, a + b, dsz, dest_is_register);
          ex.wb     = 1'b1;
        end
      end
      x86alu_pkg::CMD_INC: begin
        if (sized) begin
          ex.result = x86alu_pkg::merge(dest_value, a + 64'd1, dsz, dest_is_register);
          ex.wb     = 1'b1;
        end
      end
      x86alu_pkg::CMD_SUB: begin
        if (sized) begin
          ex.result = x86alu_pkg::merge(dest_value, a - b, dsz, dest_is_register);
          ex.wb     = 1'b1;
        end
      end
      x86alu_pkg::CMD_CMP: begin
        if (sized) ex.flags = cmp_flags;
      end
      x86alu_pkg::CMD_IMUL: begin
        if (sized) begin
          ex.is_mul = 1'b1;
          ex.wb     = 1'b1;
        end
      end
      x86alu_pkg::CMD_AND: begin
        if (sized) begin
          ex.result = x86alu_pkg::merge(dest_value, a & b, dsz, dest_is_register);
          ex.wb     = 1'b1;
        end
      end
      x86alu_pkg::CMD_OR: begin
        if (sized) begin
          ex.result = x86alu_pkg::merge(dest_value, a | b, dsz, dest_is_register);
          ex.wb     = 1'b1;
        end
      end
      x86alu_pkg::CMD_XOR: begin
        if (sized) begin
          ex.result = x86alu_pkg::merge(dest_value, a ^ b, dsz, dest_is_register);
          ex.wb     = 1'b1;
        end
      end
      x86alu_pkg::CMD_TEST: begin
        if (sized) ex.flags = test_flags;
      end
      x86alu_pkg::CMD_SHL: begin
        if (sized) begin
          ex.result = x86alu_pkg::merge(dest_value, a << cnt, dsz, dest_is_register);
          ex.wb     = 1'b1;
        end
      end
      x86alu_pkg::CMD_SHR: begin
        if (sized) begin
          ex.result = x86alu_pkg::merge(dest_value, a >> cnt, dsz, dest_is_register);
          ex.wb     = 1'b1;
        end
      end
      x86alu_pkg::CMD_CDQE: begin
        ex.result = x86alu_pkg::sext32(dest_value);
        ex.wb     = 1'b1;
      end
      x86alu_pkg::CMD_JMP: ex.taken = 1'b1;
      x86alu_pkg::CMD_JE:  ex.taken = zf;
      x86alu_pkg::CMD_JNE: ex.taken = !zf;
      x86alu_pkg::CMD_JBE: ex.taken = cf || zf;
      x86alu_pkg::CMD_JL:  ex.taken = lt;
      x86alu_pkg::CMD_JGE: ex.taken = !lt;
      x86alu_pkg::CMD_JLE: ex.taken = zf || lt;
      default: ;
    endcase
  end

endmodule

/* rtl/x86alu_finish.sv */
// Product sum and final merge for imul; other results pass straight on.
`timescale 1ns / 1ps

module x86alu_finish (
  input  x86alu_pkg::exec_t ex,
  output logic [63:0]       result_value
);

  logic [63:0] prod;
  logic [31:0] cross_sum;

  always_comb begin
    cross_sum = ex.p_lh + ex.p_hl;
    prod      = ex.p_ll + {cross_sum, 32'd0};
    if (ex.is_mul) result_value = (ex.result & ex.keep) | (prod & ex.mask);
    else result_value = ex.result;
  end

endmodule

/* rtl/x86alu_checker.sv */
// Port-level checker for the x86 integer ALU, bound to the top level.
`timescale 1ns / 1ps
`include "x86_integer_alu_with_flags_defines.svh"

module x86alu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] result_value,
  input logic        write_back,
  input logic        branch_taken,
  input logic [5:0]  flag_bits
);

  `X86ALU_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(flag_bits) && $stable(write_back) && $stable(branch_taken), "stalled result changed")
  `X86ALU_ASSERT(a_jump_no_wb, out_valid && branch_taken |-> !write_back, "taken jump with write back")
  `X86ALU_ASSERT(a_no_false_stall, !out_valid || !out_stall |-> !in_stall, "input stalled with free output")
  `X86ALU_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid, "output valid after reset")

endmodule

bind x86_integer_alu_with_flags x86alu_checker u_checker (.*);

/* tb/x86_integer_alu_with_flags_checker.sv */
// Watches the ALU channels and config port, predicts each result and compares it.
`timescale 1ns / 1ps

module x86_integer_alu_with_flags_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [4:0]  cmd,
  input  logic        dest_is_register,
  input  logic [7:0]  dest_size,
  input  logic [7:0]  src_size,
  input  logic [63:0] dest_value,
  input  logic [63:0] src_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] result_value,
  input  logic        write_back,
  input  logic        branch_taken,
  input  logic [5:0]  flag_bits,
  output int          fails,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    logic [63:0] value;
    logic        wb;
    logic        taken;
    logic [5:0]  flags;
  } alu_result_t;

  logic [7:0]  code_b, code_w, code_d, code_q;
  logic [5:0]  flags_q;
  alu_result_t due_results[$];
  alu_result_t want, got;

  function automatic x86alu_pkg::sz_t size_of(input logic [7:0] c);
    if (c == code_q) return x86alu_pkg::SZ_QWORD;
    if (c == code_d) return x86alu_pkg::SZ_DWORD;
    if (c == code_w) return x86alu_pkg::SZ_WORD;
    if (c == code_b) return x86alu_pkg::SZ_BYTE;
    return x86alu_pkg::SZ_NONE;
  endfunction

  function automatic logic [63:0] width_mask(input x86alu_pkg::sz_t sz);
    case (sz)
      x86alu_pkg::SZ_QWORD: return 64'hFFFF_FFFF_FFFF_FFFF;
      x86alu_pkg::SZ_DWORD: return 64'h0000_0000_FFFF_FFFF;
      x86alu_pkg::SZ_WORD:  return 64'h0000_0000_0000_FFFF;
      default:              return 64'h0000_0000_0000_00FF;
    endcase
  endfunction

  function automatic logic [63:0] top_bit(input x86alu_pkg::sz_t sz);
    logic [63:0] m;
    m = width_mask(sz);
    return m & ~(m >> 1);
  endfunction

  // x86 register write rules: dword to a register clears the upper half
  function automatic logic [63:0] sized_write(input logic [63:0] d, input logic [63:0] v,
                                              input x86alu_pkg::sz_t sz, input logic is_reg);
    logic [63:0] m;
    m = width_mask(sz);
    if (sz == x86alu_pkg::SZ_QWORD || (sz == x86alu_pkg::SZ_DWORD && is_reg)) return v & m;
    return (d & ~m) | (v & m);
  endfunction

  function automatic logic [5:0] flag_base(input logic [63:0] r, input x86alu_pkg::sz_t sz);
    logic [5:0] f;
    f = '0;
    f[x86alu_pkg::FLAG_PF] = ~^r[7:0];
    f[x86alu_pkg::FLAG_ZF] = (r == 64'd0);
    f[x86alu_pkg::FLAG_SF] = |(r & top_bit(sz));
    return f;
  endfunction

  function automatic alu_result_t execute_op(input logic [4:0] op, input logic is_reg,
                                             input logic [7:0] dcode, input logic [7:0] scode,
                                             input logic [63:0] d, input logic [63:0] s);
    x86alu_pkg::sz_t dsz, ssz;
    logic [63:0]     m, a, b, r, t;
    logic [5:0]      cnt, f;
    logic            do_write, zf, cf, lt;
    alu_result_t     o;
    dsz = size_of(dcode);
    ssz = size_of(scode);
    m = width_mask(dsz);
    a = d & m;
    b = s & m;
    r = '0;
    cnt = (dsz == x86alu_pkg::SZ_QWORD) ? s[5:0] : {1'b0, s[4:0]};
    do_write = 1'b0;
    zf = flags_q[x86alu_pkg::FLAG_ZF];
    cf = flags_q[x86alu_pkg::FLAG_CF];
    lt = flags_q[x86alu_pkg::FLAG_SF] ^ flags_q[x86alu_pkg::FLAG_OF];
    o.value = d;
    o.wb = 1'b0;
    o.taken = 1'b0;
    o.flags = flags_q;
    case (op)
      x86alu_pkg::CMD_MOV: begin r = s; do_write = 1'b1; end
      x86alu_pkg::CMD_MOVZX: begin
        if ((dsz == x86alu_pkg::SZ_QWORD || dsz == x86alu_pkg::SZ_DWORD) &&
            (ssz == x86alu_pkg::SZ_WORD || ssz == x86alu_pkg::SZ_BYTE)) begin
          o.value = sized_write(d, s & width_mask(ssz), dsz, is_reg);
          o.wb = 1'b1;
        end else if (dsz == x86alu_pkg::SZ_WORD) begin
          o.value = sized_write(d, {56'd0, s[7:0]}, x86alu_pkg::SZ_WORD, is_reg);
          o.wb = 1'b1;
        end
      end
      x86alu_pkg::CMD_MOVSXD: begin o.value = {{32{s[31]}}, s[31:0]}; o.wb = 1'b1; end
      x86alu_pkg::CMD_CDQE:   begin o.value = {{32{d[31]}}, d[31:0]}; o.wb = 1'b1; end
      x86alu_pkg::CMD_ADD:  begin r = a + b; do_write = 1'b1; end
      x86alu_pkg::CMD_INC:  begin r = a + 64'd1; do_write = 1'b1; end
      x86alu_pkg::CMD_SUB:  begin r = a - b; do_write = 1'b1; end
      x86alu_pkg::CMD_IMUL: begin r = a * b; do_write = 1'b1; end
      x86alu_pkg::CMD_AND:  begin r = a & b; do_write = 1'b1; end
      x86alu_pkg::CMD_OR:   begin r = a | b; do_write = 1'b1; end
      x86alu_pkg::CMD_XOR:  begin r = a ^ b; do_write = 1'b1; end
      x86alu_pkg::CMD_SHL:  begin r = a << cnt; do_write = 1'b1; end
      x86alu_pkg::CMD_SHR:  begin r = a >> cnt; do_write = 1'b1; end
      x86alu_pkg::CMD_CMP: begin
        if (dsz != x86alu_pkg::SZ_NONE) begin
          r = (a - b) & m;
          t = a ^ b ^ r;
          f = flag_base(r, dsz);
          f[x86alu_pkg::FLAG_CF] = (a < b);
          f[x86alu_pkg::FLAG_AF] = t[4];
          f[x86alu_pkg::FLAG_OF] = |((a ^ b) & (a ^ r) & top_bit(dsz));
          o.flags = f;
        end
      end
      x86alu_pkg::CMD_TEST: if (dsz != x86alu_pkg::SZ_NONE) o.flags = flag_base(a & b, dsz);
      x86alu_pkg::CMD_JMP:  o.taken = 1'b1;
      x86alu_pkg::CMD_JE:   o.taken = zf;
      x86alu_pkg::CMD_JNE:  o.taken = !zf;
      x86alu_pkg::CMD_JBE:  o.taken = cf | zf;
      x86alu_pkg::CMD_JL:   o.taken = lt;
      x86alu_pkg::CMD_JGE:  o.taken = !lt;
      x86alu_pkg::CMD_JLE:  o.taken = zf | lt;
      default: ;
    endcase
    if (do_write && dsz != x86alu_pkg::SZ_NONE) begin
      o.value = sized_write(d, r, dsz, is_reg);
      o.wb = 1'b1;
    end
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      code_b = x86alu_pkg::RESET_CODE_B;
      code_w = x86alu_pkg::RESET_CODE_W;
      code_d = x86alu_pkg::RESET_CODE_D;
      code_q = x86alu_pkg::RESET_CODE_Q;
      flags_q = '0;
      fails = 0;
      checked = 0;
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          x86alu_pkg::REG_CODE_B: code_b = pwdata[7:0];
          x86alu_pkg::REG_CODE_W: code_w = pwdata[7:0];
          x86alu_pkg::REG_CODE_D: code_d = pwdata[7:0];
          x86alu_pkg::REG_CODE_Q: code_q = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          fails++;
          $display("%0t ns: unexpected result transfer, value %h", $time, result_value);
        end else begin
          want = due_results.pop_front();
          checked++;
          if (result_value !== want.value) begin
            fails++;
            $display("%0t ns: result_value expected %h got %h", $time, want.value,
                     result_value);
          end
          if (write_back !== want.wb) begin
            fails++;
            $display("%0t ns: write_back expected %b got %b", $time, want.wb, write_back);
          end
          if (branch_taken !== want.taken) begin
            fails++;
            $display("%0t ns: branch_taken expected %b got %b", $time, want.taken,
                     branch_taken);
          end
          if (flag_bits !== want.flags) begin
            fails++;
            $display("%0t ns: flag_bits expected %b got %b", $time, want.flags, flag_bits);
          end
        end
      end
      if (in_valid && !in_stall) begin
        got = execute_op(cmd, dest_is_register, dest_size, src_size, dest_value, src_value);
        flags_q = got.flags;
        due_results.push_back(got);
      end
    end
    pending = due_results.size();
  end

endmodule

/* tb/x86_integer_alu_with_flags_tb.sv */
// Top of the x86 integer ALU testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module x86_integer_alu_with_flags_tb;

  localparam logic [4:0] CMD_SPARE_TOP = 5'd31;
  localparam int HOLD_CYCLES = 150;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [4:0]  cmd;
  logic        dest_is_register;
  logic [7:0]  dest_size, src_size;
  logic [63:0] dest_value, src_value;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] result_value;
  logic        write_back, branch_taken;
  logic [5:0]  flag_bits;

  int fails, pending, checked;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_reqs = 0;
  int holds_done = 0;
  int hold_left = 0;
  int n_sent = 0;
  int n_settings = 0;
  logic [7:0] codes [4];

  always #6 clk = ~clk;

  x86_integer_alu_with_flags dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .dest_is_register(dest_is_register), .dest_size(dest_size),
    .src_size(src_size), .dest_value(dest_value), .src_value(src_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .write_back(write_back), .branch_taken(branch_taken),
    .flag_bits(flag_bits)
  );

  x86_integer_alu_with_flags_checker checker_i (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .dest_is_register(dest_is_register), .dest_size(dest_size),
    .src_size(src_size), .dest_value(dest_value), .src_value(src_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .write_back(write_back), .branch_taken(branch_taken),
    .flag_bits(flag_bits),
    .fails(fails), .pending(pending), .checked(checked)
  );

  initial begin
    #2_000_000;
    $display("x86_integer_alu_with_flags regression: fail");
    $finish;
  end

  // output side: random stalls plus requested long hold-offs
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != holds_done) begin
      out_stall <= 1'b1;
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic send(input logic [4:0] op, input logic is_reg, input logic [7:0] dc,
                      input logic [7:0] sc, input logic [63:0] d, input logic [63:0] s);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cmd <= op;
    dest_is_register <= is_reg;
    dest_size <= dc;
    src_size <= sc;
    dest_value <= d;
    src_value <= s;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    codes[idx] = val;
  endtask

  task automatic set_codes(input logic [7:0] b, input logic [7:0] w, input logic [7:0] d,
                           input logic [7:0] q);
    wait_idle();
    reg_write(x86alu_pkg::REG_CODE_B, b);
    reg_write(x86alu_pkg::REG_CODE_W, w);
    reg_write(x86alu_pkg::REG_CODE_D, d);
    reg_write(x86alu_pkg::REG_CODE_Q, q);
    n_settings++;
  endtask

  function automatic logic [7:0] pick_code();
    if ($urandom_range(99) < 85) return codes[$urandom_range(3)];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4: return {32'd0, $urandom_range(70)};
      5: return {32'd0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // cmp/test are often followed by a jump (JMP or a conditional one) on the fresh flags
  task automatic random_items(input int n);
    int          count;
    logic [4:0]  op;
    logic [63:0] d, s;
    count = 0;
    while (count < n) begin
      if ($urandom_range(99) < 6) begin
        op = 5'($urandom_range(CMD_SPARE_TOP, x86alu_pkg::CMD_JLE + 1));
      end else begin
        op = 5'($urandom_range(x86alu_pkg::CMD_JLE, x86alu_pkg::CMD_MOV));
      end
      d = pick_value();
      case ($urandom_range(3))
        0: s = d;
        1: s = d ^ (64'd1 << $urandom_range(63));
        default: s = pick_value();
      endcase
      send(op, 1'($urandom_range(1)), pick_code(), pick_code(), d, s);
      count++;
      if ((op == x86alu_pkg::CMD_CMP || op == x86alu_pkg::CMD_TEST) && $urandom_range(1)) begin
        send(5'($urandom_range(x86alu_pkg::CMD_JLE, x86alu_pkg::CMD_JMP)),
             1'($urandom_range(1)), pick_code(), pick_code(), pick_value(), pick_value());
        count++;
      end
    end
  endtask

  initial begin
    logic [7:0]  cb, cw, cdw, cq;
    logic [63:0] ones;
    ones = 64'hFFFF_FFFF_FFFF_FFFF;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    cmd = x86alu_pkg::CMD_NOP;
    dest_is_register = 1'b0;
    dest_size = '0;
    src_size = '0;
    dest_value = '0;
    src_value = '0;
    codes[x86alu_pkg::REG_CODE_B] = x86alu_pkg::RESET_CODE_B;
    codes[x86alu_pkg::REG_CODE_W] = x86alu_pkg::RESET_CODE_W;
    codes[x86alu_pkg::REG_CODE_D] = x86alu_pkg::RESET_CODE_D;
    codes[x86alu_pkg::REG_CODE_Q] = x86alu_pkg::RESET_CODE_Q;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle = 17;
    recv_idle = 52;
    n_settings = 1;
    cb = codes[x86alu_pkg::REG_CODE_B];
    cw = codes[x86alu_pkg::REG_CODE_W];
    cdw = codes[x86alu_pkg::REG_CODE_D];
    cq = codes[x86alu_pkg::REG_CODE_Q];
    send(x86alu_pkg::CMD_MOV, 1'b1, cdw, 8'h00, ones, 64'h1234_5678_9ABC_DEF0);
    send(x86alu_pkg::CMD_MOV, 1'b0, cdw, 8'h00, ones, 64'h1234_5678_9ABC_DEF0);
    send(x86alu_pkg::CMD_MOVZX, 1'b1, cq, cb, ones, 64'hFFFF_FFFF_FFFF_FF80);
    send(x86alu_pkg::CMD_MOVZX, 1'b0, cdw, cw, ones, 64'hFFFF_FFFF_FFFF_8001);
    send(x86alu_pkg::CMD_MOVZX, 1'b1, cq, cq, 64'd5, ones);
    send(x86alu_pkg::CMD_MOVZX, 1'b1, cw, 8'h00, ones, 64'h1FF);
    send(x86alu_pkg::CMD_MOVZX, 1'b1, cb, cb, 64'd7, ones);
    send(x86alu_pkg::CMD_MOVSXD, 1'b0, 8'h00, 8'h00, 64'd0, 64'h0000_0001_8000_0001);
    send(x86alu_pkg::CMD_CDQE, 1'b1, 8'h00, 8'h00, 64'h1234_5678_FFFF_FFFF, 64'd0);
    send(x86alu_pkg::CMD_ADD, 1'b1, cb, 8'h00, 64'hFF, 64'h01);
    send(x86alu_pkg::CMD_INC, 1'b0, cw, 8'h00, 64'hFFFF_FFFF, 64'd0);
    send(x86alu_pkg::CMD_SUB, 1'b1, cq, 8'h00, 64'd0, 64'd1);
    send(x86alu_pkg::CMD_CMP, 1'b1, cb, 8'h00, 64'h80, 64'h01);
    send(x86alu_pkg::CMD_JL, 1'b1, cb, 8'h00, 64'h4000, 64'd0);
    send(x86alu_pkg::CMD_CMP, 1'b1, cq, 8'h00, 64'd5, 64'd5);
    send(x86alu_pkg::CMD_JE, 1'b1, cb, 8'h00, 64'h4010, 64'd0);
    send(x86alu_pkg::CMD_CMP, 1'b1, cdw, 8'h00, 64'd0, 64'd1);
    send(x86alu_pkg::CMD_JBE, 1'b1, cb, 8'h00, 64'h4020, 64'd0);
    send(x86alu_pkg::CMD_TEST, 1'b1, cw, 8'h00, 64'h8000, 64'hFFFF);
    send(x86alu_pkg::CMD_CMP, 1'b1, 8'h00, 8'h00, 64'd1, 64'd1);
    send(x86alu_pkg::CMD_JLE, 1'b0, 8'h00, 8'h00, 64'h4030, 64'd0);
    send(x86alu_pkg::CMD_IMUL, 1'b1, cdw, 8'h00, 64'hFFFF_FFFF, 64'hFFFF_FFFF);
    send(x86alu_pkg::CMD_SHL, 1'b1, cq, 8'h00, 64'd1, 64'd127);
    send(x86alu_pkg::CMD_SHR, 1'b0, cdw, 8'h00, ones, 64'd33);
    send(x86alu_pkg::CMD_XOR, 1'b1, 8'h00, 8'h00, 64'd3, 64'd3);
    send(CMD_SPARE_TOP, 1'b1, cq, cq, ones, ones);
    random_items(550);

    set_codes(8'd0, 8'd255, 8'd1, 8'd254);
    send_idle = 52;
    recv_idle = 17;
    random_items(550);

    set_codes(8'd7, 8'd7, 8'd200, 8'd200);
    send_idle = 0;
    recv_idle = 0;
    hold_reqs++;
    random_items(400);

    set_codes(8'd255, 8'd0, 8'd0, 8'd255);
    random_items(400);

    wait_idle();
    repeat (8) @(negedge clk);
    $display("covered %0d transfers in, %0d results checked, %0d size-code settings",
             n_sent, checked, n_settings);
    $display("idle mixes on both sides, a long output hold-off and pauses to drain");
    if (fails == 0) begin
      $display("x86_integer_alu_with_flags regression: pass");
    end else begin
      $display("x86_integer_alu_with_flags regression: fail");
    end
    $finish;
  end

endmodule
